/* rtl/core/seconds_to_calendar_date_time_top_assert.svh */
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_time_top assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_TIME_TOP_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_TIME_TOP_ASSERT_SVH

// condition holds in the same cycle
`define S2CAL_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define S2CAL_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/s2cal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2cal_pkg
// shared widths, register indexes and calendar tables for the seconds to
// calendar date and time converter
// ----------------------------------------------------------------------------
package s2cal_pkg;

  // payload widths
  localparam int ELAPSED_W = 32;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int SECOND_W  = 6;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_HOURS   = 3'd0,
    CFG_BASE_MINUTES = 3'd1,
    CFG_BASE_SECONDS = 3'd2,
    CFG_BASE_DAY     = 3'd3,
    CFG_BASE_MONTH   = 3'd4,
    CFG_BASE_YEAR    = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic [HOUR_W-1:0]   RST_HOURS   = 5'd11;
  localparam logic [MINUTE_W-1:0] RST_MINUTES = 6'd48;
  localparam logic [SECOND_W-1:0] RST_SECONDS = 6'd0;
  localparam logic [DAY_W-1:0]    RST_DAY     = 5'd3;
  localparam logic [MONTH_W-1:0]  RST_MONTH   = 4'd10;
  localparam logic [YEAR_W-1:0]   RST_YEAR    = 16'd2019;

  // month numbers
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // divisors used by the shared divide step
  typedef enum logic [1:0] {
    DV_YEAR,
    DV_DAY,
    DV_HOUR,
    DV_MIN
  } div_sel_t;

  function automatic logic [ELAPSED_W-1:0] div_const(input div_sel_t sel);
    logic [ELAPSED_W-1:0] d;
    case (sel)
      DV_YEAR: d = 32'd400;
      DV_DAY:  d = 32'd86400;
      DV_HOUR: d = 32'd3600;
      DV_MIN:  d = 32'd60;
      default: d = 32'd60;
    endcase
    return d;
  endfunction

  // days in a common year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = 5'd28;
      default:                                    n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/s2cal_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2cal channel interfaces
// valid/ready channels for the elapsed-seconds input and the date result
// ----------------------------------------------------------------------------

// elapsed-seconds input channel
interface s2cal_in_if
  import s2cal_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_seconds;

  modport source (output valid, output elapsed_seconds, input ready);
  modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

// calendar date and time result channel
interface s2cal_out_if
  import s2cal_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour_now;
  logic [MINUTE_W-1:0] minute_now;
  logic [SECOND_W-1:0] second_now;
  logic [DAY_W-1:0]    day_now;
  logic [MONTH_W-1:0]  month_now;
  logic [YEAR_W-1:0]   year_now;

  modport source (output valid, output hour_now, output minute_now, output second_now,
                  output day_now, output month_now, output year_now, input ready);
  modport sink   (input valid, input hour_now, input minute_now, input second_now,
                  input day_now, input month_now, input year_now, output ready);
endinterface
`default_nettype wire

/* rtl/core/seconds_to_calendar_date_time_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_time_top
// Converts an elapsed-seconds count into time of day and calendar date,
// relative to a programmable base time and date. One item is worked at a
// time by a small microcoded sequencer over a shared divide-step datapath.
// The month walk crosses one month per cycle. The input is taken again as
// soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_date_time_top_assert.svh"

module seconds_to_calendar_date_time_top
  import s2cal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  s2cal_in_if.sink                   in_chan,
  s2cal_out_if.source                out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W   = 4;
  localparam int QUO_W   = 16;
  localparam int OFF_W   = 17;
  localparam int DACC_W  = 17;
  localparam int Y400_W  = 9;

  // microprogram steps
  typedef enum logic [3:0] {
    S_YLD, S_DIVY, S_YSET, S_ADD, S_DIVD, S_DSET,
    S_DIVH, S_HSET, S_DIVM, S_MSET, S_WALK, S_DONE
  } step_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_YLD, OP_DIV, OP_YSET, OP_ADD, OP_DSET, OP_HSET, OP_MSET, OP_WALK, OP_DONE
  } uop_t;

  // jump conditions: fall through, loop on count, loop while walking, wait on output
  typedef enum logic [1:0] {
    JC_NEXT, JC_CNT, JC_WALK, JC_OUT
  } ucond_t;

  typedef struct packed {
    uop_t             op;
    div_sel_t         dsel;
    ucond_t           cond;
    step_t            tgt;
    logic [CNT_W-1:0] cnt_ld;
  } uword_t;

  // control store
  function automatic uword_t urom(input step_t a);
    uword_t w;
    case (a)
      S_YLD:  w = '{op: OP_YLD,  dsel: DV_YEAR, cond: JC_NEXT, tgt: S_YLD,  cnt_ld: 4'd7};
      S_DIVY: w = '{op: OP_DIV,  dsel: DV_YEAR, cond: JC_CNT,  tgt: S_DIVY, cnt_ld: 4'd15};
      S_YSET: w = '{op: OP_YSET, dsel: DV_DAY,  cond: JC_NEXT, tgt: S_YSET, cnt_ld: 4'd15};
      S_ADD:  w = '{op: OP_ADD,  dsel: DV_DAY,  cond: JC_NEXT, tgt: S_ADD,  cnt_ld: 4'd15};
      S_DIVD: w = '{op: OP_DIV,  dsel: DV_DAY,  cond: JC_CNT,  tgt: S_DIVD, cnt_ld: 4'd4};
      S_DSET: w = '{op: OP_DSET, dsel: DV_HOUR, cond: JC_NEXT, tgt: S_DSET, cnt_ld: 4'd4};
      S_DIVH: w = '{op: OP_DIV,  dsel: DV_HOUR, cond: JC_CNT,  tgt: S_DIVH, cnt_ld: 4'd5};
      S_HSET: w = '{op: OP_HSET, dsel: DV_MIN,  cond: JC_NEXT, tgt: S_HSET, cnt_ld: 4'd5};
      S_DIVM: w = '{op: OP_DIV,  dsel: DV_MIN,  cond: JC_CNT,  tgt: S_DIVM, cnt_ld: 4'd0};
      S_MSET: w = '{op: OP_MSET, dsel: DV_MIN,  cond: JC_NEXT, tgt: S_MSET, cnt_ld: 4'd0};
      S_WALK: w = '{op: OP_WALK, dsel: DV_MIN,  cond: JC_WALK, tgt: S_WALK, cnt_ld: 4'd0};
      S_DONE: w = '{op: OP_DONE, dsel: DV_MIN,  cond: JC_OUT,  tgt: S_DONE, cnt_ld: 4'd0};
      default: w = '{op: OP_DONE, dsel: DV_MIN, cond: JC_OUT,  tgt: S_DONE, cnt_ld: 4'd0};
    endcase
    return w;
  endfunction

  // configuration registers
  logic [HOUR_W-1:0]   base_hours_r;
  logic [MINUTE_W-1:0] base_minutes_r;
  logic [SECOND_W-1:0] base_seconds_r;
  logic [DAY_W-1:0]    base_day_r;
  logic [MONTH_W-1:0]  base_month_r;
  logic [YEAR_W-1:0]   base_year_r;

  // control
  logic             busy_r, busy_nxt;
  step_t            step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [ELAPSED_W-1:0] acc_r, acc_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [DACC_W-1:0]    day_r, day_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [Y400_W-1:0]    y400_r, y400_nxt;
  logic [HOUR_W-1:0]    hour_r, hour_nxt;
  logic [MINUTE_W-1:0]  minute_r, minute_nxt;
  logic [SECOND_W-1:0]  second_r, second_nxt;

  // output register
  logic [HOUR_W-1:0]   out_hour_r;
  logic [MINUTE_W-1:0] out_minute_r;
  logic [SECOND_W-1:0] out_second_r;
  logic [DAY_W-1:0]    out_day_r;
  logic [MONTH_W-1:0]  out_month_r;
  logic [YEAR_W-1:0]   out_year_r;
  logic                load_out;

  uword_t               uw;
  logic                 in_beat;
  logic                 slot_free;
  logic [ELAPSED_W-1:0] dsh;
  logic                 fits;
  logic [OFF_W-1:0]     offset;
  logic [MONTH_W-1:0]   month_clamp;
  logic                 leap;
  logic [DAY_W-1:0]     mlen;
  logic                 walk_more;

  // handshake
  assign in_chan.ready = !busy_r;
  assign in_beat       = in_chan.valid && !busy_r;
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hour_now   = out_hour_r;
  assign out_chan.minute_now = out_minute_r;
  assign out_chan.second_now = out_second_r;
  assign out_chan.day_now    = out_day_r;
  assign out_chan.month_now  = out_month_r;
  assign out_chan.year_now   = out_year_r;

  assign uw = urom(step_r);

  // shared restoring divide step
  assign dsh  = div_const(uw.dsel) << cnt_r;
  assign fits = acc_r >= dsh;

  // base time of day in seconds
  assign offset = OFF_W'(base_hours_r) * OFF_W'(3600)
                + OFF_W'(base_minutes_r) * OFF_W'(60)
                + OFF_W'(base_seconds_r);

  // out-of-range base month is pulled into January..December
  always_comb begin
    if (base_month_r < MONTH_JAN) begin
      month_clamp = MONTH_JAN;
    end else if (base_month_r > MONTH_DEC) begin
      month_clamp = MONTH_DEC;
    end else begin
      month_clamp = base_month_r;
    end
  end

  // gregorian leap rule on the year modulo 400
  assign leap = (y400_r == 9'd0)
             || ((y400_r != 9'd100) && (y400_r != 9'd200) && (y400_r != 9'd300)
                 && (y400_r[1:0] == 2'd0));
  assign mlen = month_days(month_r) + DAY_W'((month_r == MONTH_FEB) && leap);
  assign walk_more = day_r > DACC_W'(mlen);

  // sequencer and datapath next state
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    y400_nxt      = y400_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    load_out      = 1'b0;

    if (busy_r) begin
      // operation of the current control word
      case (uw.op)
        OP_YLD: begin
          acc_nxt = ELAPSED_W'(base_year_r);
          quo_nxt = '0;
        end
        OP_DIV: begin
          if (fits) begin
            acc_nxt        = acc_r - dsh;
            quo_nxt[cnt_r] = 1'b1;
          end
        end
        OP_YSET: begin
          y400_nxt  = acc_r[Y400_W-1:0];
          year_nxt  = base_year_r;
          month_nxt = month_clamp;
          acc_nxt   = ELAPSED_W'(offset);
        end
        OP_ADD: begin
          acc_nxt = acc_r + elapsed_r;
          quo_nxt = '0;
        end
        OP_DSET: begin
          day_nxt = DACC_W'(base_day_r) + DACC_W'(quo_r);
          quo_nxt = '0;
        end
        OP_HSET: begin
          hour_nxt = quo_r[HOUR_W-1:0];
          quo_nxt  = '0;
        end
        OP_MSET: begin
          minute_nxt = quo_r[MINUTE_W-1:0];
        end
        OP_WALK: begin
          if (walk_more) begin
            day_nxt = day_r - DACC_W'(mlen);
            if (month_r == MONTH_DEC) begin
              month_nxt = MONTH_JAN;
              year_nxt  = year_r + 16'd1;
              // year 0 after the 16-bit wrap is 0 modulo 400
              y400_nxt  = ((y400_r == 9'd399) || (year_r == 16'hFFFF)) ? 9'd0
                                                                      : y400_r + 9'd1;
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end
        end
        OP_DONE: begin
          load_out = slot_free;
        end
        default: begin
          load_out = 1'b0;
        end
      endcase

      // step counter and jumps
      if ((uw.cond == JC_CNT) && (cnt_r != '0)) begin
        cnt_nxt = cnt_r - 4'd1;
      end else begin
        cnt_nxt = uw.cnt_ld;
      end
      case (uw.cond)
        JC_NEXT: step_nxt = step_t'(step_r + 4'd1);
        JC_CNT:  step_nxt = (cnt_r != '0) ? uw.tgt : step_t'(step_r + 4'd1);
        JC_WALK: step_nxt = walk_more ? uw.tgt : step_t'(step_r + 4'd1);
        JC_OUT: begin
          step_nxt = uw.tgt;
          busy_nxt = !slot_free;
        end
        default: step_nxt = uw.tgt;
      endcase
    end else if (in_beat) begin
      busy_nxt = 1'b1;
      step_nxt = S_YLD;
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    if (busy_r && (uw.op == OP_MSET)) begin
      second_nxt = acc_r[SECOND_W-1:0];
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      step_r         <= S_YLD;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      base_hours_r   <= RST_HOURS;
      base_minutes_r <= RST_MINUTES;
      base_seconds_r <= RST_SECONDS;
      base_day_r     <= RST_DAY;
      base_month_r   <= RST_MONTH;
      base_year_r    <= RST_YEAR;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BASE_HOURS:   base_hours_r   <= cfg_data[HOUR_W-1:0];
          CFG_BASE_MINUTES: base_minutes_r <= cfg_data[MINUTE_W-1:0];
          CFG_BASE_SECONDS: base_seconds_r <= cfg_data[SECOND_W-1:0];
          CFG_BASE_DAY:     base_day_r     <= cfg_data[DAY_W-1:0];
          CFG_BASE_MONTH:   base_month_r   <= cfg_data[MONTH_W-1:0];
          CFG_BASE_YEAR:    base_year_r    <= cfg_data[YEAR_W-1:0];
          default:          base_year_r    <= base_year_r;
        endcase
      end
    end
  end

  // datapath and output registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      elapsed_r <= in_chan.elapsed_seconds;
    end
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    y400_r   <= y400_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    if (load_out) begin
      out_hour_r   <= hour_r;
      out_minute_r <= minute_r;
      out_second_r <= second_r;
      out_day_r    <= day_r[DAY_W-1:0];
      out_month_r  <= month_r;
      out_year_r   <= year_r;
    end
  end

  // checks
  `S2CAL_AST_NOW(a_month_range, busy_r && (step_r > S_YSET), (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC), "month left january..december")
  `S2CAL_AST_NOW(a_y400_range, busy_r && (step_r > S_YSET), y400_r < 9'd400, "year modulo 400 out of range")
  `S2CAL_AST_NOW(a_day_done, busy_r && (step_r == S_DONE), day_r <= 17'd31, "day not reduced by month walk")
  `S2CAL_AST_NXT(a_out_src, !out_valid_r && !(busy_r && (step_r == S_DONE)), !out_valid_r, "result shown without finished item")

endmodule
`default_nettype wire
